// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bounding box checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define MWBB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked across reset.
`define MWBB_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mwbb_pkg.sv =====
// ----------------------------------------------------------------------------
// Mesh world bounding box package
// Widths, register indices, reset values and the configuration type.
// ----------------------------------------------------------------------------
package mwbb_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 12;

    localparam int POS_W       = 16;
    localparam int COEF_W      = 16;
    localparam int OUT_W       = 21;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 128;
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_TRANSFORM_EN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_X        = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_Y        = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_Z        = 2'd3;

    localparam logic [CFG_DATA_W-1:0] ROW_X_RESET = 64'h1000_0000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] ROW_Y_RESET = 64'h0000_1000_0000_0000;
    localparam logic [CFG_DATA_W-1:0] ROW_Z_RESET = 64'h0000_0000_1000_0000;

    typedef struct packed {
        logic                  transform_en;
        logic [CFG_DATA_W-1:0] row_x;
        logic [CFG_DATA_W-1:0] row_y;
        logic [CFG_DATA_W-1:0] row_z;
    } t_cfg;

endpackage

// ===== rtl/core/mwbb_front.sv =====
// ----------------------------------------------------------------------------
// Bounding box front end
// Accepts vertices and keeps the running box; pushes each finished box.
// ----------------------------------------------------------------------------
module mwbb_front import mwbb_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]    i_s_axis_tdata,
    input  logic                     i_s_axis_tlast,
    input  logic                     i_q_full,
    output logic                     o_q_push,
    output logic [6*COORD_WIDTH-1:0] o_q_data
);

    logic                          r_first;
    logic signed [COORD_WIDTH-1:0] r_min [3];
    logic signed [COORD_WIDTH-1:0] r_max [3];
    logic signed [COORD_WIDTH-1:0] n_min [3];
    logic signed [COORD_WIDTH-1:0] n_max [3];
    logic signed [COORD_WIDTH-1:0] w_pos [3];
    logic                          w_accept;

    assign o_s_axis_tready = !i_q_full;
    assign w_accept        = i_s_axis_tvalid && !i_q_full;
    assign o_q_push        = w_accept && i_s_axis_tlast;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [POS_W-1:0] w_field;
        assign w_field = i_s_axis_tdata[a*POS_W +: POS_W];
        if (COORD_WIDTH <= POS_W) begin : g_narrow
            assign w_pos[a] = signed'(w_field[COORD_WIDTH-1:0]);
        end else begin : g_wide
            assign w_pos[a] = COORD_WIDTH'(w_field);
        end
        always_comb begin
            n_min[a] = (r_first || (w_pos[a] < r_min[a])) ? w_pos[a] : r_min[a];
            n_max[a] = (r_first || (w_pos[a] > r_max[a])) ? w_pos[a] : r_max[a];
        end
        assign o_q_data[a*COORD_WIDTH +: COORD_WIDTH]     = n_min[a];
        assign o_q_data[(a+3)*COORD_WIDTH +: COORD_WIDTH] = n_max[a];
        always_ff @(posedge i_clk) begin
            if (w_accept) begin
                r_min[a] <= n_min[a];
                r_max[a] <= n_max[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (w_accept) begin
            r_first <= i_s_axis_tlast;
        end
    end

endmodule

// ===== rtl/core/mwbb_queue.sv =====
// ----------------------------------------------------------------------------
// Box queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module mwbb_queue import mwbb_pkg::*; #(
    parameter int DATA_W = 6*COORD_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/core/mwbb_back.sv =====
// ----------------------------------------------------------------------------
// Bounding box back end
// Maps a finished box via the world matrix if enabled; holds the result word.
// ----------------------------------------------------------------------------
module mwbb_back import mwbb_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_q_valid,
    input  logic [6*COORD_WIDTH-1:0] i_q_data,
    output logic                     o_q_pop,
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    localparam int PROD_W = COORD_WIDTH + COEF_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int PAD_W  = OUT_TDATA_W - 6*OUT_W;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]                    r_state;
    logic [1:0]                    r_axis;
    logic [1:0]                    r_col;
    logic signed [COORD_WIDTH-1:0] r_mn [3];
    logic signed [COORD_WIDTH-1:0] r_mx [3];
    logic signed [PROD_W-1:0]      r_pa;
    logic signed [PROD_W-1:0]      r_pb;
    logic signed [ACC_W-1:0]       r_acc_lo;
    logic signed [ACC_W-1:0]       r_acc_hi;
    logic [OUT_W-1:0]              r_res_lo [3];
    logic [OUT_W-1:0]              r_res_hi [3];
    logic                          r_out_valid;
    logic [OUT_TDATA_W-1:0]        r_out_data;

    logic [CFG_DATA_W-1:0]         w_row;
    logic signed [COEF_W-1:0]      w_coef;
    logic signed [POS_W-1:0]       w_trans;
    logic signed [COORD_WIDTH-1:0] w_cmn;
    logic signed [COORD_WIDTH-1:0] w_cmx;
    logic signed [PROD_W-1:0]      w_plo;
    logic signed [PROD_W-1:0]      w_phi;
    logic signed [ACC_W-1:0]       w_rlo;
    logic signed [ACC_W-1:0]       w_rhi;
    logic signed [COORD_WIDTH-1:0] w_qmn [3];
    logic signed [COORD_WIDTH-1:0] w_qmx [3];
    logic                          w_out_free;

    for (genvar a = 0; a < 3; a++) begin : g_unpack
        assign w_qmn[a] = i_q_data[a*COORD_WIDTH +: COORD_WIDTH];
        assign w_qmx[a] = i_q_data[(a+3)*COORD_WIDTH +: COORD_WIDTH];
    end

    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        case (r_axis)
            2'd0:    w_row = i_cfg.row_x;
            2'd1:    w_row = i_cfg.row_y;
            default: w_row = i_cfg.row_z;
        endcase
        case (r_col)
            2'd0: begin
                w_coef = w_row[63:48];
                w_cmn  = r_mn[0];
                w_cmx  = r_mx[0];
            end
            2'd1: begin
                w_coef = w_row[47:32];
                w_cmn  = r_mn[1];
                w_cmx  = r_mx[1];
            end
            default: begin
                w_coef = w_row[31:16];
                w_cmn  = r_mn[2];
                w_cmx  = r_mx[2];
            end
        endcase
        w_trans = w_row[15:0];
        w_plo   = (r_pa < r_pb) ? r_pa : r_pb;
        w_phi   = (r_pa < r_pb) ? r_pb : r_pa;
        w_rlo   = ((r_acc_lo + HALF) >>> FRAC_BITS) + ACC_W'(w_trans);
        w_rhi   = ((r_acc_hi + HALF) >>> FRAC_BITS) + ACC_W'(w_trans);
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    for (int a = 0; a < 3; a++) begin
                        r_mn[a]     <= w_qmn[a];
                        r_mx[a]     <= w_qmx[a];
                        r_res_lo[a] <= OUT_W'(w_qmn[a]);
                        r_res_hi[a] <= OUT_W'(w_qmx[a]);
                    end
                end
            end
            ST_MUL: begin
                r_pa <= PROD_W'(w_coef) * PROD_W'(w_cmn);
                r_pb <= PROD_W'(w_coef) * PROD_W'(w_cmx);
            end
            ST_ACC: begin
                r_acc_lo <= (r_col == 2'd0) ? ACC_W'(w_plo) : r_acc_lo + ACC_W'(w_plo);
                r_acc_hi <= (r_col == 2'd0) ? ACC_W'(w_phi) : r_acc_hi + ACC_W'(w_phi);
            end
            ST_FIN: begin
                case (r_axis)
                    2'd0: begin
                        r_res_lo[0] <= w_rlo[OUT_W-1:0];
                        r_res_hi[0] <= w_rhi[OUT_W-1:0];
                    end
                    2'd1: begin
                        r_res_lo[1] <= w_rlo[OUT_W-1:0];
                        r_res_hi[1] <= w_rhi[OUT_W-1:0];
                    end
                    default: begin
                        r_res_lo[2] <= w_rlo[OUT_W-1:0];
                        r_res_hi[2] <= w_rhi[OUT_W-1:0];
                    end
                endcase
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_out_data <= {PAD_W'(0), r_res_hi[2], r_res_hi[1], r_res_hi[0],
                                   r_res_lo[2], r_res_lo[1], r_res_lo[0]};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= 2'd0;
            r_col       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_axis  <= 2'd0;
                        r_col   <= 2'd0;
                        r_state <= i_cfg.transform_en ? ST_MUL : ST_OUT;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (r_col == 2'd2) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_col   <= r_col + 2'd1;
                        r_state <= ST_MUL;
                    end
                end
                ST_FIN: begin
                    r_col <= 2'd0;
                    if (r_axis == 2'd2) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/core/mesh_world_bounding_box_core.sv =====
// ----------------------------------------------------------------------------
// Mesh world bounding box core: vertices are taken at one per cycle unless stalled.
// Input stalls only while two finished boxes wait; the back end takes one box at a time.
// A box passes the queue, back end states (MUL/ACC/FIN if mapped) and output register.
// Reset is synchronous, active low: clears box state, loads identity matrix.
// ----------------------------------------------------------------------------
module mesh_world_bounding_box_core import mwbb_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // pos_x, pos_y, pos_z
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic                   i_s_axis_tlast,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int BOX_W = 6*COORD_WIDTH;

    t_cfg             r_cfg;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_q_valid;
    logic [BOX_W-1:0] w_push_data;
    logic [BOX_W-1:0] w_q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.transform_en <= 1'b0;
            r_cfg.row_x        <= ROW_X_RESET;
            r_cfg.row_y        <= ROW_Y_RESET;
            r_cfg.row_z        <= ROW_Z_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRANSFORM_EN: r_cfg.transform_en <= i_cfg_data[0];
                CFG_ROW_X:        r_cfg.row_x        <= i_cfg_data;
                CFG_ROW_Y:        r_cfg.row_y        <= i_cfg_data;
                CFG_ROW_Z:        r_cfg.row_z        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mwbb_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_q_full        (w_full),
        .o_q_push        (w_push),
        .o_q_data        (w_push_data)
    );

    mwbb_queue #(
        .DATA_W (BOX_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    mwbb_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (w_q_valid),
        .i_q_data        (w_q_data),
        .o_q_pop         (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// ===== rtl/core/mwbb_checker.sv =====
// ----------------------------------------------------------------------------
// Bounding box port checker
// Watches the result stream of the core and is bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mwbb_checker import mwbb_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    `MWBB_ASSERT_NR(a_no_result_after_reset, i_clk, !$past(i_rst_n) |-> !o_m_axis_tvalid, "result word shown straight after reset")
    `MWBB_ASSERT(a_valid_holds, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "result word withdrawn while stalled")
    `MWBB_ASSERT(a_data_holds, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata), "result word changed while stalled")
    `MWBB_ASSERT(a_box_ordered_x, i_clk, i_rst_n, o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[20:0]) <= $signed(o_m_axis_tdata[83:63])), "box minimum x exceeds maximum x")

endmodule

bind mesh_world_bounding_box_core mwbb_checker u_mwbb_checker (.*);
